// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the bitmap block allocator
// no dependencies; imported by every module of the block

package bba_pkg;

  // default sizing of the bitmap
  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int DEF_WORD_BITS  = 32;

  // field widths fixed by the stream format
  localparam int LIMIT_W  = 13;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // latch request, issue first bitmap read
    logic scan;      // test current word, read next one
    logic free_wr;   // clear the bit of the freed block
    logic load_out;  // move result into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_mode;   // mode of the beat on the input
    logic range_err; // input index at or above the limit
    logic hit;       // current word has a free block below the limit
    logic last;      // current word is the last one under the limit
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

// ===== src/bba_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine of the bitmap block allocator
// depends on bba_pkg; drives the datapath through cmd_t, reads sts_t

module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FREE = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.in_mode == MODE_ALLOC) begin
            state_next = ST_SCAN;
          end else if (sts.range_err) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_FREE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last) begin
          state_next = ST_RESP;
        end
      end
      ST_FREE: begin
        cmd.free_wr = 1'b1;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bba_dp.sv =====
`timescale 1ns / 1ps
// datapath of the bitmap block allocator: bitmap memory, word scan, output register
// depends on bba_pkg; commanded by bba_ctrl

module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS   // power of two
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [bba_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic [bba_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bba_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import bba_pkg::*;

  localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int LIMW  = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (LIMW > LIMIT_W) ? LIMW : LIMIT_W;

  localparam logic [CW-1:0] MAX_LIM = CW'(MAX_BLOCKS);
  localparam logic [AW-1:0] LAST_W  = AW'(WORDS - 1);
  localparam logic [CW:0]   WB_C    = (CW + 1)'(WORD_BITS);

  // configuration and limit
  logic [LIMIT_W-1:0] block_limit;
  logic [CW-1:0]      lim;

  // bitmap memory and its read stage
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] data_eff;
  logic                 rd_valid;
  logic [AW-1:0]        rtag;
  logic [AW-1:0]        raddr;
  logic [AW:0]          fill;
  logic                 wen;
  logic [WORD_BITS-1:0] wdata;

  // request fields
  logic               in_mode;
  logic [INDEX_W-1:0] in_index;
  logic [CW-1:0]      in_ext;
  logic [INDEX_W-1:0] req;
  logic [CW-1:0]      req_ext;
  logic [BW-1:0]      req_bit;

  // scan of one word
  logic [CW-1:0]        base;
  logic [CW-1:0]        rem;
  logic [CW:0]          top;
  logic [WORD_BITS-1:0] free_mask;
  logic                 hit;
  logic [BW-1:0]        hit_bit;
  logic                 last;
  logic [CW-1:0]        gidx;

  // result staging
  logic [INDEX_W-1:0]  res_idx;
  logic [STATUS_W-1:0] res_status;

  assign in_mode  = s_axis_tdata[0];
  assign in_index = s_axis_tdata[INDEX_W:1];
  assign in_ext   = CW'(in_index);
  assign req_ext  = CW'(req);
  assign req_bit  = req_ext[BW-1:0];

  // limit register, saturated to the bitmap size
  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      block_limit <= cfg_data;
    end
  end

  assign lim = (CW'(block_limit) > MAX_LIM) ? MAX_LIM : CW'(block_limit);

  // read address: word zero for an allocate or the word of the freed block on a new request, then walk upward
  always_comb begin
    if (cmd.accept) begin
      raddr = (in_mode == MODE_FREE) ? in_ext[BW +: AW] : '0;
    end else begin
      raddr = rtag + 1'b1;
    end
  end

  // words at or above the fill mark were never written and read as zero
  assign data_eff = rd_valid ? rd_data : '0;

  // scan of the word in the read stage
  assign base = CW'(rtag) << BW;
  assign rem  = (base < lim) ? (lim - base) : '0;
  assign top  = {1'b0, base} + WB_C;
  assign last = (top >= {1'b0, lim}) || (rtag == LAST_W);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_mask[b] = !data_eff[b] && (CW'(b) < rem);
    end
  end

  // lowest free bit
  always_comb begin
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_mask[b]) begin
        hit_bit = BW'(b);
      end
    end
  end

  assign hit  = |free_mask;
  assign gidx = (CW'(rtag) << BW) | CW'(hit_bit);

  // bitmap update
  always_comb begin
    wen   = 1'b0;
    wdata = data_eff;
    if (cmd.scan && hit) begin
      wen   = 1'b1;
      wdata = data_eff | (WORD_BITS'(1) << hit_bit);
    end else if (cmd.free_wr && rd_valid) begin
      wen   = 1'b1;
      wdata = data_eff & ~(WORD_BITS'(1) << req_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[rtag] <= wdata;
    end
    rd_data  <= mem[raddr];
    rd_valid <= ({1'b0, raddr} < fill);
    rtag     <= raddr;
  end

  // fill mark: allocation only ever writes the word at or below it
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.scan && hit && ({1'b0, rtag} >= fill)) begin
      fill <= {1'b0, rtag} + 1'b1;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req        <= in_index;
      res_idx    <= in_index;
      res_status <= (in_ext >= lim) ? STATUS_RANGE : STATUS_OK;
    end else if (cmd.scan) begin
      if (hit) begin
        res_idx    <= gidx[INDEX_W-1:0];
        res_status <= STATUS_OK;
      end else if (last) begin
        res_idx    <= '0;
        res_status <= STATUS_FULL;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= M_DATA_W'({res_status, res_idx});
    end
  end

  // status to the controller
  assign sts.in_mode   = in_mode;
  assign sts.range_err = (in_ext >= lim);
  assign sts.hit       = hit;
  assign sts.last      = last;
  assign sts.out_free  = !m_axis_tvalid || m_axis_tready;

endmodule

// ===== src/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// top level of the bitmap first-fit block allocator
// depends on bba_pkg, bba_ctrl and bba_dp
//
// channel   direction  beat contents (lowest bit first)
// cfg       in         cfg_data: block_limit[12:0], written when cfg_we is high
// s_axis    in         mode[0], block_index[12:1], zero[15:13]
// m_axis    out        granted_index[11:0], status[13:12], zero[15:14]
//
// an allocate reads bitmap words from word zero, one per cycle (up to 128 at the default
// size), until a word has a free block or is the last under the limit; a free reads the
// word of its block and clears the bit, an out-of-range free skips the write. the
// controller is idle again once the result is loaded into the output register.
// the bitmap read of one word at a time sets the scan time.
// the bitmap needs no clearing pass: a fill mark makes unwritten words read as free.
// a new request is taken while the last result waits in the output register;
// a stalled output holds the next result in the datapath staging registers.

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bba_pkg::LIMIT_W-1:0]  cfg_data,       // block_limit
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bba_pkg::S_DATA_W-1:0] s_axis_tdata,   // mode, block_index, pad
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bba_pkg::M_DATA_W-1:0] m_axis_tdata    // granted_index, status, pad
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  bba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // datapath
  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== src/bba_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the bitmap block allocator, bound to the top level
// depends on bba_pkg and bitmap_block_allocator

module bba_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bba_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import bba_pkg::*;

  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_idx;

  assign out_status = m_axis_tdata[INDEX_W +: STATUS_W];
  assign out_idx    = m_axis_tdata[INDEX_W-1:0];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one request at a time: input closes after a beat is taken
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input stayed open after a request beat");

  // only defined status codes, pad bits zero
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_status == STATUS_OK || out_status == STATUS_FULL ||
                       out_status == STATUS_RANGE) &&
                      m_axis_tdata[M_DATA_W-1:INDEX_W+STATUS_W] == '0)
    else $error("bad status code or pad bits on result");

  // a full bitmap reports index zero
  a_full_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status == STATUS_FULL |-> out_idx == '0)
    else $error("full status with nonzero index");

endmodule

bind bitmap_block_allocator bba_port_checks u_bba_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
